>>> src/rbc_pkg.sv
// Retry backoff controller package: widths, codes and item structs.
// Used by every module of the block; no dependencies.
`default_nettype none

package rbc_pkg;

  localparam int DELAY_BITS = 24;
  localparam int COUNT_BITS = 8;
  localparam int SHIFT_W    = $clog2(DELAY_BITS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [2:0] {
    ACT_CLEAR    = 3'd0,
    ACT_SET_REQ  = 3'd1,
    ACT_SET_DISC = 3'd2,
    ACT_RETRY    = 3'd3,
    ACT_QUERY    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STRAT_IMMEDIATE = 2'd0,
    STRAT_FIXED     = 2'd1,
    STRAT_LINEAR    = 2'd2,
    STRAT_EXP       = 2'd3
  } strategy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRATEGY    = 2'd0,
    REG_BASE_DELAY  = 2'd1,
    REG_MAX_DELAY   = 2'd2,
    REG_MAX_RETRIES = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] action;
    logic       flag_value;
  } in_t;

  typedef struct packed {
    logic                  retry_needed;
    logic                  limit_reached;
    logic [COUNT_BITS-1:0] retries_so_far;
    logic [DELAY_BITS-1:0] next_delay;
    logic                  request_failed;
    logic                  disconnect_failed;
  } out_t;

endpackage

`default_nettype wire

>>> src/rbc_delay.sv
// Next-delay calculation for the retry backoff controller.
// Combinational; depends on rbc_pkg.
`default_nettype none

module rbc_delay
  import rbc_pkg::*;
(
  input  wire strategy_t             strategy,
  input  wire logic [DELAY_BITS-1:0] base_delay,
  input  wire logic [DELAY_BITS-1:0] max_delay,
  input  wire logic [COUNT_BITS-1:0] count,
  output logic      [DELAY_BITS-1:0] delay
);

  logic [DELAY_BITS+COUNT_BITS-1:0] lin_prod;
  logic [DELAY_BITS-1:0]            lin_delay;
  logic [COUNT_BITS-1:0]            exp_k;
  logic [2*DELAY_BITS-1:0]          exp_shift;
  logic [DELAY_BITS-1:0]            exp_delay;
  logic [DELAY_BITS-1:0]            base_clamped;

  always_comb begin
    lin_prod  = base_delay * count;
    lin_delay = (lin_prod > {{COUNT_BITS{1'b0}}, max_delay}) ? max_delay
                                                             : lin_prod[DELAY_BITS-1:0];

    base_clamped = (base_delay > max_delay) ? max_delay : base_delay;

    exp_k     = count - COUNT_BITS'(1);
    exp_shift = {{DELAY_BITS{1'b0}}, base_delay} << SHIFT_W'(exp_k);
    if (count <= COUNT_BITS'(1)) begin
      exp_delay = base_clamped;
    end else if (base_delay == '0) begin
      exp_delay = '0;
    end else if (32'(exp_k) >= DELAY_BITS) begin
      // any nonzero base shifted this far exceeds the clamp
      exp_delay = max_delay;
    end else if (exp_shift > {{DELAY_BITS{1'b0}}, max_delay}) begin
      exp_delay = max_delay;
    end else begin
      exp_delay = exp_shift[DELAY_BITS-1:0];
    end

    unique case (strategy)
      STRAT_IMMEDIATE: delay = '0;
      STRAT_FIXED:     delay = base_delay;
      STRAT_LINEAR:    delay = lin_delay;
      STRAT_EXP:       delay = exp_delay;
      default:         delay = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/retry_backoff_controller.sv
// Retry backoff controller: an accepted item is registered into the state and s1_valid, then
// its result into out_item. Throughput one item per cycle while the output is not stalled;
// the state update sits in the accept cycle, the delay multiply/shift and clamp sit in
// the result stage. rst (synchronous) clears count, flags, all configuration registers
// and both stage valids. Depends on rbc_pkg and rbc_delay.
`default_nettype none

module retry_backoff_controller
  import rbc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_item,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  strategy_t             strategy;
  logic [DELAY_BITS-1:0] base_delay;
  logic [DELAY_BITS-1:0] max_delay;
  logic [COUNT_BITS-1:0] max_retries;

  logic [COUNT_BITS-1:0] retry_count, retry_count_next;
  logic                  request_flag, request_flag_next;
  logic                  disconnect_flag, disconnect_flag_next;

  logic                  s1_valid;
  logic                  out_ready;
  logic                  in_acc;
  logic                  reached;
  logic [DELAY_BITS-1:0] delay;
  out_t                  result;

  assign cfg_ready = 1'b1;
  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_ready;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    retry_count_next     = retry_count;
    request_flag_next    = request_flag;
    disconnect_flag_next = disconnect_flag;
    unique case (in_item.action)
      ACT_CLEAR: begin
        retry_count_next     = '0;
        request_flag_next    = 1'b0;
        disconnect_flag_next = 1'b0;
      end
      ACT_SET_REQ:  request_flag_next    = in_item.flag_value;
      ACT_SET_DISC: disconnect_flag_next = in_item.flag_value;
      ACT_RETRY: begin
        if (retry_count != '1) retry_count_next = retry_count + COUNT_BITS'(1);
      end
      default: ;
    endcase
  end

  rbc_delay u_delay (
    .strategy   (strategy),
    .base_delay (base_delay),
    .max_delay  (max_delay),
    .count      (retry_count),
    .delay      (delay)
  );

  always_comb begin
    reached                  = retry_count >= max_retries;
    result.retry_needed      = request_flag && disconnect_flag && !reached;
    result.limit_reached     = reached;
    result.retries_so_far    = retry_count;
    result.next_delay        = delay;
    result.request_failed    = request_flag;
    result.disconnect_failed = disconnect_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy        <= STRAT_IMMEDIATE;
      base_delay      <= '0;
      max_delay       <= '0;
      max_retries     <= '0;
      retry_count     <= '0;
      request_flag    <= 1'b0;
      disconnect_flag <= 1'b0;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_STRATEGY:    strategy    <= strategy_t'(cfg_data[1:0]);
          REG_BASE_DELAY:  base_delay  <= cfg_data[DELAY_BITS-1:0];
          REG_MAX_DELAY:   max_delay   <= cfg_data[DELAY_BITS-1:0];
          REG_MAX_RETRIES: max_retries <= cfg_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        retry_count     <= retry_count_next;
        request_flag    <= request_flag_next;
        disconnect_flag <= disconnect_flag_next;
      end
      s1_valid <= in_acc || (s1_valid && !out_ready);
      if (out_ready) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) out_item <= result;
  end

  // checks
  a_needed_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.retry_needed |->
      out_item.request_failed && out_item.disconnect_failed && !out_item.limit_reached)
    else $error("retry_needed without both flags or with limit reached");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_item.action == ACT_CLEAR |=>
      retry_count == '0 && !request_flag && !disconnect_flag)
    else $error("clear did not clear state");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst && !(in_acc && in_item.action == ACT_CLEAR) |=>
      retry_count >= $past(retry_count))
    else $error("retry count decreased without clear");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_ready |=> s1_valid && $stable(retry_count))
    else $error("pending item lost or state changed while stalled");

endmodule

`default_nettype wire
